[src/mmds_pkg.sv]
// ----------------------------------------------------------------------------
// mmds_pkg: shared definitions of the moving mean deviation signal
// Types, configuration register indexes, reset values and fixed widths
// used by the signal block.
// ----------------------------------------------------------------------------
package mmds_pkg;

   // Fixed widths of the configuration registers and internal arithmetic.
   localparam int WLEN_W   = 9;
   localparam int COOL_W   = 16;
   localparam int ENTRY_W  = 17;
   localparam int QTY_W    = 32;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int SUM_W    = 64;
   localparam int HALF_W   = 32;
   localparam int CTR_W    = 17;
   localparam int SCALE_W  = 14;

   localparam int PLO_W    = ENTRY_W + HALF_W;
   localparam int RHS_W    = ENTRY_W + SUM_W;
   localparam int DSC_W    = SUM_W + SCALE_W;

   // Basis points per unit.
   localparam logic [SCALE_W-1:0] SCALE_BPS = SCALE_W'(10000);
   localparam logic [CTR_W-1:0]   CTR_MAX   = '1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_OFF   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOT_SIZE   = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [WLEN_W-1:0]  WINDOW_LEN_RST = WLEN_W'(20);
   localparam logic [COOL_W-1:0]  HOLD_OFF_RST   = '0;
   localparam logic [ENTRY_W-1:0] THRESHOLD_RST  = ENTRY_W'(50);
   localparam logic [QTY_W-1:0]   LOT_SIZE_RST   = QTY_W'(1);

   // Side codes.
   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIFF,
      ST_SCALE,
      ST_DECIDE
   } state_type;

endpackage

[src/moving_mean_deviation_signal_top.sv]
// ----------------------------------------------------------------------------
// moving_mean_deviation_signal_top: moving mean deviation trading signal
// Keeps a window of recent mid prices in a memory with a running sum and
// emits a buy or sell when the price strays far enough from the mean.
// ----------------------------------------------------------------------------
// One request carries one mid price and is handled to completion before the
// next one is taken. A zero price is accepted and changes nothing. A
// non-zero price passes through ST_SUM alone when the window is not yet full
// or the cool-down is still running, and on through ST_DIFF, ST_SCALE and
// ST_DECIDE when a decision is made; a decision that fires waits further
// only while the previous result still sits unread in the output register.
// The ST_SUM step comes from the history memory: the oldest price is read
// in the accept cycle and its registered data only joins the running sum in
// the cycle after. ST_DIFF, ST_SCALE and ST_DECIDE carry the threshold
// test, whose 64-bit by 17-bit product is formed in two 32-bit halves
// before the final wide compare. The history memory needs no clearing pass:
// data read back is used only from entries that were written.
module moving_mean_deviation_signal_top
   import mmds_pkg::*;
#(
   parameter int WINDOW_MAX = 256,
   parameter int PRICE_BITS = 48
) (
   input  logic                   clock,
   input  logic                   reset,

   // Configuration write port.
   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]       csr_data,

   // Price requests.
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PRICE_BITS-1:0]  req_mid_price,

   // Trade results.
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_side,
   output logic [QTY_W-1:0]       rsp_quantity
);

   // Pointer indexes the history memory; the count must also hold the
   // window size itself.
   localparam int PTR_W  = $clog2(WINDOW_MAX);
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
   localparam int OLD_W  = CNT_W + 1;
   localparam int WCMP_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

   // Control state.
   state_type              state_ff, state_in;
   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CTR_W-1:0]       ctr_ff, ctr_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Configuration registers.
   logic [WLEN_W-1:0]      window_len_ff;
   logic [COOL_W-1:0]      hold_off_ff;
   logic [ENTRY_W-1:0]     threshold_ff;
   logic [QTY_W-1:0]       lot_size_ff;

   // Per-request working registers.
   logic [PRICE_BITS-1:0]  price_ff, price_in;
   logic                   evict_ff, evict_in;
   logic                   full_ff, full_in;
   logic [SUM_W-1:0]       scaled_ff, scaled_in;
   logic                   below_ff, below_in;
   logic [SUM_W-1:0]       diff_ff, diff_in;
   logic [PLO_W-1:0]       plo_ff, plo_in;
   logic [PLO_W-1:0]       phi_ff, phi_in;
   logic [DSC_W-1:0]       dsc_ff, dsc_in;
   logic                   rsp_side_ff, rsp_side_in;
   logic [QTY_W-1:0]       rsp_quantity_ff, rsp_quantity_in;

   // History memory.
   logic [PRICE_BITS-1:0]  hist_mem [WINDOW_MAX];
   logic [PRICE_BITS-1:0]  rd_data_ff;
   logic [PTR_W-1:0]       oldest;
   logic                   mem_access;

   // Combinational helpers.
   logic                   accept;
   logic                   accept_nz;
   logic [WCMP_W-1:0]      wlen_ext;
   logic [CNT_W-1:0]       eff;
   logic [CNT_W:0]         cnt_inc;
   logic                   evict_c;
   logic [CNT_W-1:0]       cnt_new;
   logic [OLD_W-1:0]       old_raw;
   logic [RHS_W-1:0]       rhs;
   logic                   hit;
   logic                   out_free;

   assign req_stall    = (state_ff != ST_IDLE);
   assign accept       = req_valid && !req_stall;
   assign accept_nz    = accept && (req_mid_price != '0);
   assign mem_access   = accept_nz;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_side     = rsp_side_ff;
   assign rsp_quantity = rsp_quantity_ff;

   // The output register can take a new result when empty or being drained.
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // Effective window: zero acts as one, oversize is clipped to the memory.
   assign wlen_ext = WCMP_W'(window_len_ff);
   always_comb begin
      priority if (wlen_ext == '0) begin
         eff = CNT_W'(1);
      end else if (wlen_ext > WCMP_W'(WINDOW_MAX)) begin
         eff = CNT_W'(WINDOW_MAX);
      end else begin
         eff = CNT_W'(wlen_ext);
      end
   end

   // Adding a price evicts the oldest one whenever the held count would
   // exceed the window; a shrunk window thus keeps its held count, one in, one out.
   assign cnt_inc = {1'b0, count_ff} + OLD_W'(1);
   assign evict_c = cnt_inc > {1'b0, eff};
   assign cnt_new = evict_c ? count_ff : cnt_inc[CNT_W-1:0];

   // Slot of the oldest held price; it equals the write slot when the memory is full,
   // where the memory returns the value before this write.
   assign old_raw = OLD_W'(ptr_ff) + OLD_W'(WINDOW_MAX) - OLD_W'(count_ff);
   assign oldest  = (old_raw >= OLD_W'(WINDOW_MAX)) ?
                    PTR_W'(old_raw - OLD_W'(WINDOW_MAX)) : PTR_W'(old_raw);

   // Threshold product assembled from its two halves.
   assign rhs = {phi_ff, {HALF_W{1'b0}}} + RHS_W'(plo_ff);
   assign hit = RHS_W'(dsc_ff) >= rhs;

   always_ff @(posedge clock) begin
      if (mem_access) begin
         hist_mem[ptr_ff] <= req_mid_price;
         rd_data_ff       <= hist_mem[oldest];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WINDOW_LEN_RST;
         hold_off_ff   <= HOLD_OFF_RST;
         threshold_ff  <= THRESHOLD_RST;
         lot_size_ff   <= LOT_SIZE_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WINDOW_LEN: window_len_ff <= csr_data[WLEN_W-1:0];
            CSR_HOLD_OFF:   hold_off_ff   <= csr_data[COOL_W-1:0];
            CSR_THRESHOLD:  threshold_ff  <= csr_data[ENTRY_W-1:0];
            CSR_LOT_SIZE:   lot_size_ff   <= csr_data[QTY_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         ctr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         ctr_ff       <= ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff        <= price_in;
      evict_ff        <= evict_in;
      full_ff         <= full_in;
      scaled_ff       <= scaled_in;
      below_ff        <= below_in;
      diff_ff         <= diff_in;
      plo_ff          <= plo_in;
      phi_ff          <= phi_in;
      dsc_ff          <= dsc_in;
      rsp_side_ff     <= rsp_side_in;
      rsp_quantity_ff <= rsp_quantity_in;
   end

   always_comb begin
      state_in        = state_ff;
      ptr_in          = ptr_ff;
      count_in        = count_ff;
      sum_in          = sum_ff;
      ctr_in          = ctr_ff;
      price_in        = price_ff;
      evict_in        = evict_ff;
      full_in         = full_ff;
      scaled_in       = scaled_ff;
      below_in        = below_ff;
      diff_in         = diff_ff;
      plo_in          = plo_ff;
      phi_in          = phi_ff;
      dsc_in          = dsc_ff;
      rsp_side_in     = rsp_side_ff;
      rsp_quantity_in = rsp_quantity_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept_nz) begin
               price_in = req_mid_price;
               evict_in = evict_c;
               full_in  = cnt_new >= eff;
               count_in = cnt_new;
               ptr_in   = (ptr_ff == PTR_W'(WINDOW_MAX - 1)) ? '0 : ptr_ff + PTR_W'(1);
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // The evicted price arrives from the memory in this cycle.
            sum_in    = sum_ff + SUM_W'(price_ff) -
                        (evict_ff ? SUM_W'(rd_data_ff) : '0);
            scaled_in = SUM_W'(price_ff) * SUM_W'(count_ff);
            if (!full_ff) begin
               state_in = ST_IDLE;
            end else begin
               ctr_in = (ctr_ff == CTR_MAX) ? ctr_ff : ctr_ff + CTR_W'(1);
               if (ctr_ff < CTR_W'(hold_off_ff)) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            below_in = scaled_ff <= sum_ff;
            diff_in  = (scaled_ff <= sum_ff) ? sum_ff - scaled_ff : scaled_ff - sum_ff;
            plo_in   = PLO_W'(threshold_ff) * PLO_W'(sum_ff[HALF_W-1:0]);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            phi_in   = PLO_W'(threshold_ff) * PLO_W'(sum_ff[SUM_W-1:HALF_W]);
            dsc_in   = DSC_W'(diff_ff) * DSC_W'(SCALE_BPS);
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!hit) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_side_in     = below_ff ? SIDE_BUY : SIDE_SELL;
               rsp_quantity_in = lot_size_ff;
               ctr_in          = '0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // A non-zero price always starts the sum update in the next cycle.
   a_nz_starts_sum: assert property (@(posedge clock) disable iff (reset)
      accept_nz |=> (state_ff == ST_SUM))
      else $error("non-zero price did not start the sum update");

   // Every stored price advances the write pointer.
   a_ptr_advances: assert property (@(posedge clock) disable iff (reset)
      accept_nz |=> (ptr_ff != $past(ptr_ff)))
      else $error("write pointer did not advance");

   // A zero price leaves the window untouched.
   a_zero_no_change: assert property (@(posedge clock) disable iff (reset)
      (accept && !accept_nz) |=> ($stable(sum_ff) && $stable(count_ff) &&
                                  $stable(ptr_ff) && $stable(ctr_ff)))
      else $error("zero price changed the window state");

   // The held count never exceeds the memory depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      accept |-> (count_ff <= CNT_W'(WINDOW_MAX)))
      else $error("held price count exceeds the history depth");
`endif

endmodule
